### sv/plsu_pkg.sv
// Shared types and constants of the piecewise-linear source unit.
package plsu_pkg;

  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int TIME_W  = 32;
  localparam int VALUE_W = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [INDEX_W-1:0]        point_index;
    logic [TIME_W-1:0]         point_time;
    logic signed [VALUE_W-1:0] point_value;
    logic [TIME_W-1:0]         query_time;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] level;
    logic                      in_segment;
  } out_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

### sv/plsu_div.sv
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, 32-bit quotient.
module plsu_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [2*plsu_pkg::TIME_W-1:0]      dividend,
  input  logic [plsu_pkg::TIME_W-1:0]        divisor,
  output plsu_pkg::div_ctrl_t                status,
  output logic [plsu_pkg::TIME_W-1:0]        quotient
);

  localparam int DW = 2 * plsu_pkg::TIME_W;
  localparam int SW = $clog2(DW);

  logic [DW-1:0]                   dq_r;
  logic [plsu_pkg::TIME_W-1:0]     rem_r;
  logic [plsu_pkg::TIME_W-1:0]     dvs_r;
  logic [SW-1:0]                   step_r;
  logic                            run_r;
  logic                            done_r;
  logic [plsu_pkg::TIME_W:0]       rem_sh;
  logic [plsu_pkg::TIME_W:0]       rem_diff;
  logic                            q_bit;

  // One quotient bit per cycle, most significant first.
  assign rem_sh   = {rem_r, dq_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(DW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      dq_r  <= {dq_r[DW-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[plsu_pkg::TIME_W-1:0] : rem_sh[plsu_pkg::TIME_W-1:0];
    end
  end

  assign status.start = start;
  assign status.done  = done_r;
  assign quotient     = dq_r[plsu_pkg::TIME_W-1:0];

endmodule

### sv/piecewise_linear_source_unit.sv
// Top level of the piecewise-linear source unit: breakpoint table, search sequencer, interpolation.
//
// A write transfer (command = write) stores one breakpoint in the cycle it is taken and gives no
// result; busy stays low, so writes may follow each other on every cycle. A query transfer on a
// non-empty table sets busy and walks the table one breakpoint per cycle through the registered
// read port of the breakpoint memory; if it finds a segment it then forms the interpolation with
// one 32 by 32 multiply and a bit-serial divider that yields one quotient bit per cycle. A query
// on an empty table answers without setting busy. The result appears on out_data for exactly
// one cycle with out_strobe high and cannot be held off, so the receiver must take every
// transfer as it comes. point_count may only be written while busy is low.
module piecewise_linear_source_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  plsu_pkg::in_t                 in_data,
  output logic                          out_strobe,
  output plsu_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [plsu_pkg::COUNT_W-1:0]  cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = plsu_pkg::TIME_W;
  localparam int VW = plsu_pkg::VALUE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_GO    = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;

  // Breakpoint storage: one write port, one registered read port.
  logic [TW-1:0]        time_mem  [MAX_POINTS];
  logic [VW-1:0]        value_mem [MAX_POINTS];
  logic [TW-1:0]        rd_time_r;
  logic signed [VW-1:0] rd_value_r;

  logic [2:0]                   state_r, state_nxt;
  logic [plsu_pkg::COUNT_W-1:0] point_count_r;
  logic [CW-1:0]                n_r;
  logic [CW-1:0]                idx_r;
  logic [TW-1:0]                t_r;
  logic [TW-1:0]                t0_r;
  logic signed [VW-1:0]         v0_r;
  logic [TW-1:0]                mag_r;
  logic [TW-1:0]                off_r;
  logic [TW-1:0]                span_r;
  logic                         neg_r;
  logic [2*TW-1:0]              prod_r;
  logic                         out_strobe_r;
  plsu_pkg::out_t               out_data_r;

  logic                         accept;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [CW-1:0]                n_active;
  logic                         hit;
  logic signed [VW:0]           dv;
  logic [VW:0]                  dv_mag;
  plsu_pkg::div_ctrl_t          div_st;
  logic [TW-1:0]                quo;
  logic signed [VW-1:0]         level_fin;

  assign accept  = start && !busy;
  assign wr_en   = accept && (in_data.command == plsu_pkg::CMD_WRITE) &&
                   (32'(in_data.point_index) < 32'(MAX_POINTS));
  assign wr_addr = AW'(in_data.point_index);

  // A count beyond the table depth is read as the full table.
  assign n_active = (32'(point_count_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                            : CW'(point_count_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= in_data.point_time;
      value_mem[wr_addr] <= in_data.point_value;
    end
    rd_time_r  <= time_mem[idx_r[AW-1:0]];
    rd_value_r <= value_mem[idx_r[AW-1:0]];
  end

  // In the scan state rd_*_r hold breakpoint idx_r-1 and t0_r/v0_r hold breakpoint idx_r-2.
  assign hit    = (t_r >= t0_r) && (t_r < rd_time_r);
  assign dv     = (VW+1)'(rd_value_r) - (VW+1)'(v0_r);
  assign dv_mag = dv[VW] ? (VW+1)'(-dv) : (VW+1)'(dv);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.command == plsu_pkg::CMD_QUERY) && (n_active != '0)) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: state_nxt = S_SEED;
      S_SEED: begin
        state_nxt = (n_r == CW'(1)) ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_MUL;
        end else if (idx_r == n_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL:   state_nxt = S_GO;
      S_GO:    state_nxt = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= '0;
      idx_r         <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (accept && (in_data.command == plsu_pkg::CMD_QUERY) && (n_active == '0)) begin
            out_strobe_r <= 1'b1;
          end
        end
        S_FIRST: idx_r <= idx_r + 1'b1;
        S_SEED: begin
          idx_r <= idx_r + 1'b1;
          if (n_r == CW'(1)) begin
            out_strobe_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (!hit) begin
            if (idx_r == n_r) begin
              out_strobe_r <= 1'b1;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            out_strobe_r <= 1'b1;
          end
        end
        default: idx_r <= idx_r;
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        t_r <= in_data.query_time;
        n_r <= n_active;
        out_data_r.level      <= '0;
        out_data_r.in_segment <= 1'b0;
      end
      S_SEED: begin
        t0_r <= rd_time_r;
        v0_r <= rd_value_r;
        out_data_r.level      <= rd_value_r;
        out_data_r.in_segment <= 1'b0;
      end
      S_SCAN: begin
        if (hit) begin
          neg_r  <= dv[VW];
          mag_r  <= dv_mag[TW-1:0];
          off_r  <= t_r - t0_r;
          span_r <= rd_time_r - t0_r;
        end else begin
          t0_r <= rd_time_r;
          v0_r <= rd_value_r;
          out_data_r.level      <= rd_value_r;
          out_data_r.in_segment <= 1'b0;
        end
      end
      S_MUL: prod_r <= (2*TW)'(mag_r) * (2*TW)'(off_r);
      S_DIV: begin
        if (div_st.done) begin
          out_data_r.level      <= level_fin;
          out_data_r.in_segment <= 1'b1;
        end
      end
      default: prod_r <= prod_r;
    endcase
  end

  plsu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_GO),
    .dividend (prod_r),
    .divisor  (span_r),
    .status   (div_st),
    .quotient (quo)
  );

  // The quotient never exceeds the value step, so the sum stays within the two breakpoints.
  assign level_fin = neg_r ? (v0_r - $signed(quo)) : (v0_r + $signed(quo));

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // A write transfer never produces a result.
  a_write_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == plsu_pkg::CMD_WRITE) |=> !out_strobe)
    else $error("result produced by a breakpoint write");

  // A result is only shown once the sequencer has returned to idle.
  a_strobe_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (state_r == S_IDLE))
    else $error("result strobe while a query is still in progress");

  // The divider only finishes while the sequencer waits for it.
  a_div_done : assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  // The scan index stays within the breakpoints in use.
  a_scan_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= n_r && idx_r >= CW'(2)))
    else $error("scan index outside the active table");

  // An interpolated result is always flagged as inside a segment.
  a_div_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_st.done) |=> (out_strobe && out_data.in_segment))
    else $error("interpolated result lost or not flagged");

endmodule

### tb/plsu_result_checker.sv
// Result checker of the piecewise-linear source unit: it predicts every query and compares.
module plsu_result_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  plsu_pkg::in_t                 in_data,
  input  logic                          out_strobe,
  input  plsu_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [plsu_pkg::COUNT_W-1:0]  cfg_wdata,
  output int unsigned                   failures,
  output int unsigned                   outstanding
);
  import plsu_pkg::*;

  logic [TIME_W-1:0]  bp_time  [MAX_POINTS];
  logic [VALUE_W-1:0] bp_value [MAX_POINTS];
  logic [COUNT_W-1:0] points_in_use;
  out_t               expected_levels [$];
  out_t               oldest;

  // Level at time t from the local copy of the breakpoint table.
  function automatic out_t interpolate(input logic [TIME_W-1:0] t);
    out_t               r;
    int unsigned        n;
    logic signed [63:0] v0;
    logic signed [63:0] v1;
    logic signed [63:0] dv;
    logic [63:0]        mag;
    logic [63:0]        off;
    logic [63:0]        span;
    logic [63:0]        quot;
    logic [63:0]        sum;
    r = '0;
    n = (points_in_use > MAX_POINTS) ? MAX_POINTS : points_in_use;
    for (int k = 1; k < n && !r.in_segment; k++) begin
      if (t >= bp_time[k-1] && t < bp_time[k]) begin
        v0   = {{32{bp_value[k-1][VALUE_W-1]}}, bp_value[k-1]};
        v1   = {{32{bp_value[k][VALUE_W-1]}}, bp_value[k]};
        dv   = v1 - v0;
        mag  = dv[63] ? -dv : dv;
        off  = {32'd0, t - bp_time[k-1]};
        span = {32'd0, bp_time[k] - bp_time[k-1]};
        quot = (mag * off) / span;
        sum  = dv[63] ? (v0 - quot) : (v0 + quot);
        r.level      = sum[VALUE_W-1:0];
        r.in_segment = 1'b1;
      end
    end
    if (!r.in_segment && n > 0) begin
      r.level = bp_value[n-1];
    end
    return r;
  endfunction

  // Results are retired before a new query is queued, since a result at this edge
  // always belongs to an older transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      points_in_use = '0;
      expected_levels.delete();
    end else begin
      if (out_strobe) begin
        if (expected_levels.size() == 0) begin
          failures++;
          $display("%0t: result with no query outstanding: expected none, actual level %h in_segment %b",
                   $time, out_data.level, out_data.in_segment);
        end else begin
          oldest = expected_levels.pop_front();
          if (out_data.level !== oldest.level) begin
            failures++;
            $display("%0t: level mismatch: expected %h, actual %h",
                     $time, oldest.level, out_data.level);
          end
          if (out_data.in_segment !== oldest.in_segment) begin
            failures++;
            $display("%0t: in_segment mismatch: expected %b, actual %b",
                     $time, oldest.in_segment, out_data.in_segment);
          end
        end
      end
      if (cfg_we) begin
        points_in_use = cfg_wdata;
      end
      if (start && !busy) begin
        if (in_data.command == CMD_QUERY) begin
          expected_levels.push_back(interpolate(in_data.query_time));
        end else if (in_data.point_index < MAX_POINTS) begin
          bp_time[in_data.point_index]  = in_data.point_time;
          bp_value[in_data.point_index] = in_data.point_value;
        end
      end
    end
    outstanding = expected_levels.size();
  end

endmodule

### tb/tb_piecewise_linear_source_unit.sv
// Testbench top of the piecewise-linear source unit: clock, reset, stimulus and verdict.
module tb_piecewise_linear_source_unit;
  import plsu_pkg::*;

  localparam int    MAX_POINTS    = 64;
  localparam int    RANDOM_ITEMS  = 1700;
  localparam int    SETTLE_CYCLES = 200;
  localparam int    DRAIN_LIMIT   = 20000;
  localparam longint WATCHDOG     = 64'd20_000_000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_t                in_data;
  logic               out_strobe;
  out_t               out_data;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int unsigned        failures;
  int unsigned        outstanding;

  // The stimulus keeps its own copy of the breakpoint times, only so that queries can
  // be aimed inside segments; the prediction lives entirely in the checker.
  logic [TIME_W-1:0]  loaded_time [MAX_POINTS];
  int unsigned        idle_pct;
  int unsigned        items_sent;
  int unsigned        random_base;
  int unsigned        phase;
  int unsigned        point_total;
  int unsigned        active_points;
  int unsigned        waited;
  int unsigned        slot;

  piecewise_linear_source_unit #(.MAX_POINTS(MAX_POINTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  plsu_result_checker #(.MAX_POINTS(MAX_POINTS)) level_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Presents one item and returns at the falling edge after its transfer. All inputs
  // change on falling edges only. Busy only moves on rising edges, so seeing it low at
  // a falling edge means the next rising edge takes the transfer. Start is left high so
  // that a following item can go back to back without a low pulse in between.
  task automatic send_item(input in_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(negedge clk);
    items_sent++;
  endtask

  // A write carries a random query time, so that field toggles on writes too.
  task automatic write_point(input int unsigned idx, input logic [TIME_W-1:0] t,
                             input logic [VALUE_W-1:0] v);
    in_t item;
    item.command     = CMD_WRITE;
    item.point_index = INDEX_W'(idx);
    item.point_time  = t;
    item.point_value = v;
    item.query_time  = $urandom;
    loaded_time[idx] = t;
    send_item(item);
  endtask

  // A query carries random breakpoint fields, which the block must ignore.
  task automatic query_at(input logic [TIME_W-1:0] t);
    in_t item;
    item.command     = CMD_QUERY;
    item.point_index = INDEX_W'($urandom_range(MAX_POINTS - 1));
    item.point_time  = $urandom;
    item.point_value = $urandom;
    item.query_time  = t;
    send_item(item);
  endtask

  // The count register is only written once the block has gone quiet: no query left
  // outstanding, busy low, and a few more cycles for any write still being stored.
  task automatic set_point_count(input int unsigned n);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(n);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Breakpoint values lean towards the extremes of the Q16.16 range now and then.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return VALUE_W'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // Most queries fall inside a chosen segment; the rest land exactly on a breakpoint,
  // at either end of the time axis, or anywhere at all.
  function automatic logic [TIME_W-1:0] pick_query_time(input int unsigned n);
    int unsigned       sel;
    int unsigned       k;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    sel = $urandom_range(9);
    if (n >= 2 && sel < 6) begin
      k  = $urandom_range(n - 1, 1);
      lo = loaded_time[k-1];
      hi = loaded_time[k];
      if (hi > lo) begin
        return lo + ($urandom % (hi - lo));
      end
      return lo;
    end
    if (n >= 1 && sel < 8) begin
      return loaded_time[$urandom_range(n - 1)];
    end
    if (sel == 8) begin
      return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    end
    return $urandom;
  endfunction

  // Loads slots 0 to n-1. Most tables rise in time, densely or with wide spans; some
  // hold runs of equal times, and a few are left in no order at all.
  task automatic load_table(input int unsigned n);
    logic [TIME_W-1:0] t;
    int unsigned       mode;
    mode = $urandom_range(9);
    t    = (mode < 5) ? TIME_W'($urandom_range(1000)) : TIME_W'($urandom);
    for (int i = 0; i < n; i++) begin
      write_point(i, t, pick_value());
      if (mode < 5) begin
        t = t + $urandom_range(64, 1);
      end else if (mode < 8) begin
        t = t + $urandom_range(32'h0400_0000, 1);
      end else if (mode == 8) begin
        t = t + $urandom_range(1);
      end else begin
        t = $urandom;
      end
    end
  endtask

  // Count for a random phase: mostly small tables, so that queries stay quick, with
  // the empty table, the single point, the full table and counts beyond it mixed in.
  function automatic int unsigned pick_count();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) begin
      return 0;
    end else if (sel == 1) begin
      return 1;
    end else if (sel < 12) begin
      return $urandom_range(8, 2);
    end else if (sel < 17) begin
      return $urandom_range(63, 9);
    end else if (sel == 17) begin
      return MAX_POINTS;
    end
    return $urandom_range(127, MAX_POINTS + 1);
  endfunction

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    idle_pct   = 0;
    items_sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Every slot is written first, so that no count, however large, can ever make the
    // block read a breakpoint that holds nothing yet.
    load_table(MAX_POINTS);

    // Directed part. An empty table answers zero with the flag clear.
    set_point_count(0);
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);

    // A single point has no segment, so its value is held whatever the time.
    write_point(0, 32'd100, 32'h7FFF_FFFF);
    set_point_count(1);
    query_at(32'h0000_0000);
    query_at(32'd100);
    query_at(32'hFFFF_FFFF);

    // Three points across the whole time axis: a rising segment from the most negative
    // to the most positive value, which gives the widest product, then a falling one.
    // A query at the very last tick lies in no segment and holds the last value.
    write_point(0, 32'h0000_0000, 32'h8000_0000);
    write_point(1, 32'h8000_0000, 32'h7FFF_FFFF);
    write_point(2, 32'hFFFF_FFFF, 32'h0000_0000);
    write_point(3, 32'h0000_0010, 32'h0001_0000);
    set_point_count(3);
    query_at(32'h0000_0000);
    query_at(32'h7FFF_FFFF);
    query_at(32'h8000_0000);
    query_at(32'hFFFF_FFFE);
    query_at(32'hFFFF_FFFF);

    // A fourth point earlier in time than the third: the last segment can never match,
    // so a miss now holds the fourth value.
    set_point_count(4);
    query_at(32'h0000_0010);
    query_at(32'hFFFF_FFFF);

    // Counts beyond the table size behave as a full table.
    set_point_count(127);
    query_at(32'hFFFF_FFFF);
    query_at(pick_query_time(MAX_POINTS));
    set_point_count(MAX_POINTS);
    query_at(pick_query_time(MAX_POINTS));

    // Random part. Each phase sets a count, loads a fresh table and then runs a burst of
    // queries with the odd stray write mixed in. The phases take turns at no sender
    // idling, heavy idling and light idling.
    random_base = items_sent;
    phase       = 0;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 77;
        default: idle_pct = 13;
      endcase
      point_total   = pick_count();
      active_points = (point_total > MAX_POINTS) ? MAX_POINTS : point_total;
      set_point_count(point_total);
      load_table(active_points);
      repeat ($urandom_range(40, 10)) begin
        if ($urandom_range(4) == 0) begin
          slot = $urandom_range(MAX_POINTS - 1);
          write_point(slot, $urandom_range(1) ? TIME_W'($urandom)
                                              : loaded_time[slot] + $urandom_range(8),
                      pick_value());
        end else begin
          query_at(pick_query_time(active_points));
        end
      end
      phase++;
    end

    // Let the last results drain, then allow for anything arriving late or unasked.
    start  <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (outstanding == 0 && failures == 0) begin
      $display("** piecewise_linear_source_unit: PASSED **");
    end else begin
      $display("** piecewise_linear_source_unit: FAILED **");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(WATCHDOG);
    $display("** piecewise_linear_source_unit: FAILED **");
    $finish;
  end

endmodule
